// File: sv/text_to_sprite_layout_top_assert.svh
// Assertion helpers for the layout engine RTL.
`ifndef TEXT_TO_SPRITE_LAYOUT_TOP_ASSERT_SVH
`define TEXT_TO_SPRITE_LAYOUT_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TTSL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttsl same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define TTSL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttsl next-cycle check failed");

`endif

// File: sv/ttsl_pkg.sv
`default_nettype none
package ttsl_pkg;

  localparam int GLYPHS_DEF       = 64;
  localparam int SPRITE_SLOTS_DEF = 128;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FONT_PRESENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_BASE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPECIAL_BASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT  = 3'd4;

  localparam logic [5:0] ALPHA_BASE_RST   = 6'd10;
  localparam logic [5:0] SPECIAL_BASE_RST = 6'd36;

  // Item commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CHAR = 1'b1;

  // Character codes
  localparam logic [7:0] CH_DIGIT_LO = 8'd48;
  localparam logic [7:0] CH_DIGIT_HI = 8'd57;
  localparam logic [7:0] CH_UPPER_LO = 8'd65;
  localparam logic [7:0] CH_UPPER_HI = 8'd90;
  localparam logic [7:0] CH_LOWER_LO = 8'd97;
  localparam logic [7:0] CH_LOWER_HI = 8'd122;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_PERIOD   = 8'd46;
  localparam logic [7:0] CH_COLON    = 8'd58;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic       font_present;
    logic [5:0] digit_base;
    logic [5:0] alpha_base;
    logic [5:0] special_base;
    logic [6:0] glyph_count;
  } cfg_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
    logic       first;
    logic       last;
    logic [8:0] start_x;
    logic [7:0] start_y;
    logic [6:0] oam_start;
    logic [3:0] palette;
    logic [5:0] glyph_index;
    logic [9:0] glyph_tile;
    logic [3:0] glyph_width;
    logic [7:0] glyph_code;
  } in_item_t;

  typedef struct packed {
    logic       drawn;
    logic [6:0] oam_slot;
    logic [8:0] obj_x;
    logic [7:0] obj_y;
    logic [3:0] obj_palette;
    logic [9:0] obj_tile;
    logic [7:0] drawn_count;
    logic       end_of_text;
  } res_item_t;

  typedef struct packed {
    logic [9:0] tile;
    logic [3:0] width;
    logic [7:0] code;
  } glyph_entry_t;

endpackage
`default_nettype wire

// File: sv/text_to_sprite_layout_top.sv
// Channel   Handshake             Payload              Direction
// in_       in_valid / in_ready   in_item  (in_item_t)  load or character request
// out_      out_valid / out_ready out_item (res_item_t) one result per character
// cfg_      cfg_we                cfg_index, cfg_wdata  register write, no wait
//
// A load request writes the glyph memory at acceptance.
// A character request reads one glyph entry when mapped directly and none when unknown, mapped
// past the font end or with no font; space, period and colon scan the glyph memory one
// entry a cycle from the special base up to the font end or the first matching code.
// Reset is synchronous and active low; the glyph memory is not cleared.
// A held result in the output register stalls the next character only at its end.
`default_nettype none
module text_to_sprite_layout_top
  import ttsl_pkg::*;
#(
  parameter int GLYPHS       = GLYPHS_DEF,
  parameter int SPRITE_SLOTS = SPRITE_SLOTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output res_item_t                  out_item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg_r;
  logic      out_valid_r;
  res_item_t out_item_r;
  logic      res_valid, res_ready;
  res_item_t res;

  // Configuration registers; indexes past the list drop the write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.font_present <= 1'b0;
      cfg_r.digit_base   <= '0;
      cfg_r.alpha_base   <= ALPHA_BASE_RST;
      cfg_r.special_base <= SPECIAL_BASE_RST;
      cfg_r.glyph_count  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FONT_PRESENT: cfg_r.font_present <= cfg_wdata[0];
        REG_DIGIT_BASE:   cfg_r.digit_base   <= cfg_wdata[5:0];
        REG_ALPHA_BASE:   cfg_r.alpha_base   <= cfg_wdata[5:0];
        REG_SPECIAL_BASE: cfg_r.special_base <= cfg_wdata[5:0];
        REG_GLYPH_COUNT:  cfg_r.glyph_count  <= cfg_wdata[6:0];
        default: begin
        end
      endcase
    end
  end

  // Layout engine: string state, glyph memory and the search sequencer.
  ttsl_engine #(
    .GLYPHS       (GLYPHS),
    .SPRITE_SLOTS (SPRITE_SLOTS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: take a new result whenever the held one is gone or leaving.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
        out_item_r  <= res;
      end else if (out_ready) begin
        // drop the delivered result
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// File: sv/ttsl_glyph_ram.sv
`default_nettype none
module ttsl_glyph_ram
  import ttsl_pkg::*;
#(
  parameter int GLYPHS = GLYPHS_DEF,
  localparam int GIW = $clog2(GLYPHS)
) (
  input  wire logic         clk,
  input  wire logic         we,
  input  wire logic [GIW-1:0] waddr,
  input  wire glyph_entry_t wdata,
  input  wire logic         re,
  input  wire logic [GIW-1:0] raddr,
  output glyph_entry_t      rdata
);

  glyph_entry_t mem [GLYPHS];
  glyph_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: sv/ttsl_engine.sv
`default_nettype none
`include "text_to_sprite_layout_top_assert.svh"
module ttsl_engine
  import ttsl_pkg::*;
#(
  parameter int GLYPHS       = GLYPHS_DEF,
  parameter int SPRITE_SLOTS = SPRITE_SLOTS_DEF,
  localparam int GIW = $clog2(GLYPHS),
  localparam int CW  = (GIW + 1 > 7) ? GIW + 1 : 7
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           res_valid,
  input  wire logic      res_ready,
  output res_item_t      res
);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t       state_r;
  logic [CW-1:0] ptr_r, lim_r;
  logic         any_r, pend_r;
  logic [7:0]   code_r;
  logic         last_r;
  logic [6:0]   slot_r, nslot_r;
  logic [8:0]   cursor_r;
  logic [7:0]   y_r;
  logic [3:0]   pal_r;
  logic [7:0]   cnt_r;

  glyph_entry_t rd;
  glyph_entry_t wr;
  logic         ram_we, ram_re;

  logic          accept, load_acc, char_acc;
  logic [CW-1:0] font_end, g_map, ptr_init, lim_init;
  logic          is_digit, is_upper, is_lower, is_special;
  logic          any_init;
  logic [6:0]    slot_cur, slot_inc;
  logic          issue, hit, done, finish;
  logic [7:0]    cnt_inc;

  // Reduce a 7-bit value modulo the slot count by shifted compare-subtract.
  function automatic logic [6:0] reduce_slot(input logic [6:0] v);
    logic [7:0] r;
    r = {1'b0, v};
    for (int k = 6; k >= 0; k--) begin
      if ((SPRITE_SLOTS << k) <= 127) begin
        if (r >= 8'(SPRITE_SLOTS << k)) begin
          r = r - 8'(SPRITE_SLOTS << k);
        end
      end
    end
    return r[6:0];
  endfunction

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_acc = accept && (in_item.cmd == CMD_LOAD);
  assign char_acc = accept && (in_item.cmd == CMD_CHAR);

  // Search bound: the smaller of the glyph count and the table depth.
  assign font_end = (CW'(cfg.glyph_count) < CW'(GLYPHS)) ? CW'(cfg.glyph_count)
                                                         : CW'(GLYPHS);

  always_comb begin
    is_digit   = (in_item.char_code >= CH_DIGIT_LO) && (in_item.char_code <= CH_DIGIT_HI);
    is_upper   = (in_item.char_code >= CH_UPPER_LO) && (in_item.char_code <= CH_UPPER_HI);
    is_lower   = (in_item.char_code >= CH_LOWER_LO) && (in_item.char_code <= CH_LOWER_HI);
    is_special = (in_item.char_code == CH_SPACE) || (in_item.char_code == CH_PERIOD)
              || (in_item.char_code == CH_COLON);
    g_map = '0;
    if (is_digit) begin
      g_map = CW'(in_item.char_code - CH_DIGIT_LO) + CW'(cfg.digit_base);
    end else if (is_upper) begin
      g_map = CW'(in_item.char_code - CH_UPPER_LO) + CW'(cfg.alpha_base);
    end else if (is_lower) begin
      g_map = CW'(in_item.char_code - CH_LOWER_LO) + CW'(cfg.alpha_base);
    end
    // An empty range [ptr, lim) ends the search with nothing drawn.
    ptr_init = '0;
    lim_init = '0;
    any_init = 1'b1;
    if (cfg.font_present) begin
      if (is_digit || is_upper || is_lower) begin
        if (g_map < font_end) begin
          ptr_init = g_map;
          lim_init = g_map + CW'(1);
        end
      end else if (is_special) begin
        ptr_init = CW'(cfg.special_base);
        lim_init = font_end;
        any_init = 1'b0;
      end
    end
  end

  // Slot of this character and the one after it.
  assign slot_cur = in_item.first ? reduce_slot(in_item.oam_start) : nslot_r;
  assign slot_inc = (8'(slot_cur) + 8'd1 == 8'(SPRITE_SLOTS)) ? 7'd0 : slot_cur + 7'd1;

  // Scan: one read issued per cycle, the previous read compared alongside.
  assign issue  = ptr_r < lim_r;
  assign hit    = pend_r && (any_r || (rd.code == code_r));
  assign done   = hit || !issue;
  assign res_valid = (state_r == ST_SCAN) && done;
  assign finish = res_valid && res_ready;
  assign ram_re = (state_r == ST_SCAN) && !done;

  assign cnt_inc = (hit && (cnt_r != COUNT_MAX)) ? cnt_r + 8'd1 : cnt_r;

  always_comb begin
    res.drawn       = hit;
    res.oam_slot    = slot_r;
    res.obj_x       = hit ? cursor_r : '0;
    res.obj_y       = hit ? y_r : '0;
    res.obj_palette = hit ? pal_r : '0;
    res.obj_tile    = hit ? rd.tile : '0;
    res.drawn_count = cnt_inc;
    res.end_of_text = last_r;
  end

  assign ram_we   = load_acc && (CW'(in_item.glyph_index) < CW'(GLYPHS));
  assign wr.tile  = in_item.glyph_tile;
  assign wr.width = in_item.glyph_width;
  assign wr.code  = in_item.glyph_code;

  ttsl_glyph_ram #(
    .GLYPHS(GLYPHS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (GIW'(in_item.glyph_index)),
    .wdata (wr),
    .re    (ram_re),
    .raddr (ptr_r[GIW-1:0]),
    .rdata (rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pend_r   <= 1'b0;
      cursor_r <= '0;
      y_r      <= '0;
      nslot_r  <= '0;
      pal_r    <= '0;
      cnt_r    <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (char_acc) begin
            state_r <= ST_SCAN;
            ptr_r   <= ptr_init;
            lim_r   <= lim_init;
            any_r   <= any_init;
            pend_r  <= 1'b0;
            code_r  <= in_item.char_code;
            last_r  <= in_item.last;
            slot_r  <= slot_cur;
            nslot_r <= slot_inc;
            if (in_item.first) begin
              cursor_r <= in_item.start_x;
              y_r      <= in_item.start_y;
              pal_r    <= in_item.palette;
              cnt_r    <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (!done) begin
            ptr_r  <= ptr_r + CW'(1);
            pend_r <= 1'b1;
          end else if (finish) begin
            state_r <= ST_IDLE;
            cnt_r   <= cnt_inc;
            if (hit) begin
              cursor_r <= cursor_r + 9'(rd.width);
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `TTSL_ASSERT_IMP(a_read_in_table, clk, rst_n, ram_re, ptr_r < CW'(GLYPHS))
  `TTSL_ASSERT_NXT(a_char_blocks_input, clk, rst_n, char_acc, !in_ready)
  `TTSL_ASSERT_IMP(a_drawn_needs_font, clk, rst_n, res_valid && res.drawn, cfg.font_present)
  `TTSL_ASSERT_NXT(a_stall_holds_result, clk, rst_n, res_valid && !res_ready,
                   res_valid && $stable(res))

endmodule
`default_nettype wire

// File: test/testbench.sv
module testbench;
  import ttsl_pkg::*;

  // Spare register indexes past the end of the register list; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;

  localparam int          RANDOM_PHASES    = 8;
  localparam int          REQUESTS_PER_SET = 200;
  localparam int          SATURATING_RUN   = 300;
  localparam int          SETTLE_CYCLES    = GLYPHS_DEF + 8;
  localparam int          DRAIN_LIMIT      = 20000;
  localparam int unsigned CYCLE_LIMIT      = 1000000;

  // Directed text: a string placed at the far corner, a run of unknown codes
  // right next to the mapped ranges, and a probe string for the reset registers.
  localparam logic [7:0] CORNER_TEXT [9] = '{CH_DIGIT_LO, CH_DIGIT_HI, CH_UPPER_LO,
    CH_UPPER_HI, CH_LOWER_LO, CH_LOWER_HI, CH_SPACE, CH_PERIOD, CH_COLON};
  localparam logic [7:0] STRAY_TEXT [7] = '{8'h00, 8'hFF, CH_DIGIT_LO - 8'd1,
    CH_UPPER_LO - 8'd1, CH_UPPER_HI + 8'd1, CH_LOWER_LO - 8'd1, CH_LOWER_HI + 8'd1};
  localparam logic [7:0] PROBE_TEXT  [4] = '{CH_DIGIT_LO, CH_UPPER_LO, CH_SPACE, CH_LOWER_HI};
  // With glyph_count 12 and the default bases: '9' lands inside the font,
  // 'C' maps to index 12 and falls just outside, and the space search starts past the end.
  localparam logic [7:0] EDGE_TEXT   [3] = '{CH_DIGIT_HI, CH_UPPER_LO + 8'd2, CH_SPACE};

  // Predicts the sprite that each character request should place and holds
  // the sprites still due from the block, oldest first.
  class sprite_placement_book;
    cfg_t         regs;
    glyph_entry_t glyph_mem [GLYPHS_DEF];
    logic [8:0]   cursor_x;
    logic [7:0]   line_y;
    logic [6:0]   next_slot;
    logic [3:0]   str_palette;
    logic [7:0]   drawn_so_far;
    res_item_t    sprites_due [$];
    int           mismatches;
    int           loads_seen;
    int           chars_seen;
    int           sprites_placed;

    function new();
      regs = '0;
      regs.alpha_base   = ALPHA_BASE_RST;
      regs.special_base = SPECIAL_BASE_RST;
      foreach (glyph_mem[g]) glyph_mem[g] = '0;
      cursor_x     = '0;
      line_y       = '0;
      next_slot    = '0;
      str_palette  = '0;
      drawn_so_far = '0;
      mismatches   = 0;
      loads_seen   = 0;
      chars_seen   = 0;
      sprites_placed = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FONT_PRESENT: regs.font_present = data[0];
        REG_DIGIT_BASE:   regs.digit_base   = data[5:0];
        REG_ALPHA_BASE:   regs.alpha_base   = data[5:0];
        REG_SPECIAL_BASE: regs.special_base = data[5:0];
        REG_GLYPH_COUNT:  regs.glyph_count  = data[6:0];
        default: ;
      endcase
    endfunction

    // Map a code to a glyph index; anything at or past the font end draws nothing.
    function bit find_glyph(logic [7:0] c, output int idx);
      int font_end;
      int g;
      font_end = (int'(regs.glyph_count) < GLYPHS_DEF) ? int'(regs.glyph_count) : GLYPHS_DEF;
      idx = 0;
      if (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI)
        g = int'(c - CH_DIGIT_LO) + int'(regs.digit_base);
      else if (c >= CH_UPPER_LO && c <= CH_UPPER_HI)
        g = int'(c - CH_UPPER_LO) + int'(regs.alpha_base);
      else if (c >= CH_LOWER_LO && c <= CH_LOWER_HI)
        g = int'(c - CH_LOWER_LO) + int'(regs.alpha_base);
      else if (c == CH_SPACE || c == CH_PERIOD || c == CH_COLON) begin
        for (g = int'(regs.special_base); g < font_end; g++) begin
          if (glyph_mem[g].code == c) begin
            idx = g;
            return 1'b1;
          end
        end
        return 1'b0;
      end else
        return 1'b0;
      if (g >= font_end) return 1'b0;
      idx = g;
      return 1'b1;
    endfunction

    function void note_request(in_item_t req);
      res_item_t want;
      bit        hit;
      int        idx;
      if (req.cmd == CMD_LOAD) begin
        loads_seen++;
        if (int'(req.glyph_index) < GLYPHS_DEF) begin
          glyph_mem[req.glyph_index].tile  = req.glyph_tile;
          glyph_mem[req.glyph_index].width = req.glyph_width;
          glyph_mem[req.glyph_index].code  = req.glyph_code;
        end
        return;
      end
      chars_seen++;
      if (req.first) begin
        cursor_x     = req.start_x;
        line_y       = req.start_y;
        next_slot    = 7'(int'(req.oam_start) % SPRITE_SLOTS_DEF);
        str_palette  = req.palette;
        drawn_so_far = '0;
      end
      want = '0;
      want.oam_slot = next_slot;
      next_slot = 7'((int'(next_slot) + 1) % SPRITE_SLOTS_DEF);
      hit = 1'b0;
      idx = 0;
      if (regs.font_present) hit = find_glyph(req.char_code, idx);
      if (hit) begin
        want.drawn       = 1'b1;
        want.obj_x       = cursor_x;
        want.obj_y       = line_y;
        want.obj_palette = str_palette;
        want.obj_tile    = glyph_mem[idx].tile;
        cursor_x = cursor_x + 9'(glyph_mem[idx].width);
        if (drawn_so_far != COUNT_MAX) drawn_so_far++;
        sprites_placed++;
      end
      want.drawn_count = drawn_so_far;
      want.end_of_text = req.last;
      sprites_due.push_back(want);
    endfunction

    function void field_agrees(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_sprite(res_item_t got);
      res_item_t want;
      if (sprites_due.size() == 0) begin
        $error("result for slot %0d arrived with nothing due", got.oam_slot);
        mismatches++;
        return;
      end
      want = sprites_due.pop_front();
      field_agrees("drawn",       want.drawn,       got.drawn);
      field_agrees("oam_slot",    want.oam_slot,    got.oam_slot);
      field_agrees("obj_x",       want.obj_x,       got.obj_x);
      field_agrees("obj_y",       want.obj_y,       got.obj_y);
      field_agrees("obj_palette", want.obj_palette, got.obj_palette);
      field_agrees("obj_tile",    want.obj_tile,    got.obj_tile);
      field_agrees("drawn_count", want.drawn_count, got.drawn_count);
      field_agrees("end_of_text", want.end_of_text, got.end_of_text);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  res_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  sprite_placement_book book;
  bit                   idle_on = 1'b1;
  int                   stall_left = 0;
  int unsigned          cycles_run = 0;
  int                   settings_used = 0;

  text_to_sprite_layout_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs on a handshake.
  always @(posedge clk) begin
    cycles_run++;
    if (cycles_run >= CYCLE_LIMIT) begin
      $display("text_to_sprite_layout_top regression: fail");
      $finish;
    end
  end

  // Result side: check every sprite taken at this edge, then decide whether
  // to stall the next ones.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) book.check_sprite(out_item);
    if (stall_left != 0)
      stall_left--;
    else if (idle_on && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 10);
    out_ready <= (stall_left == 0);
  end

  // Every field random to start with, so that unused bits toggle too.
  function automatic in_item_t random_request();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t char_request(logic [7:0] code, logic first, logic last);
    in_item_t req;
    req = random_request();
    req.cmd       = CMD_CHAR;
    req.char_code = code;
    req.first     = first;
    req.last      = last;
    return req;
  endfunction

  // Lean toward mapped characters and the searched specials; keep some noise.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return CH_DIGIT_LO + 8'($urandom_range(0, 9));
      3, 4:    return CH_UPPER_LO + 8'($urandom_range(0, 25));
      5:       return CH_LOWER_LO + 8'($urandom_range(0, 25));
      6, 7: begin
        case ($urandom_range(0, 2))
          0:       return CH_SPACE;
          1:       return CH_PERIOD;
          default: return CH_COLON;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [5:0] pick_base();
    case ($urandom_range(0, 3))
      0:       return 6'd0;
      1:       return 6'd63;
      default: return 6'($urandom_range(0, 63));
    endcase
  endfunction

  // Extremes are forced on the first few settings so each one is seen for sure.
  function automatic cfg_t pick_setting(int phase);
    cfg_t s;
    s.font_present = ($urandom_range(0, 4) != 0);
    s.digit_base   = pick_base();
    s.alpha_base   = pick_base();
    s.special_base = pick_base();
    case ($urandom_range(0, 4))
      0:       s.glyph_count = 7'd0;
      1:       s.glyph_count = 7'd64;
      2:       s.glyph_count = 7'($urandom_range(65, 127));
      default: s.glyph_count = 7'($urandom_range(1, 64));
    endcase
    case (phase)
      0: s = '{font_present: 1'b1, digit_base: 6'd0, alpha_base: 6'd0,
               special_base: 6'd0, glyph_count: 7'd64};
      1: s = '{font_present: 1'b1, digit_base: 6'd63, alpha_base: 6'd63,
               special_base: 6'd63, glyph_count: 7'd64};
      2: s.font_present = 1'b0;
      3: begin
        s.font_present = 1'b1;
        s.glyph_count  = 7'd0;
      end
      4: begin
        s.font_present = 1'b1;
        s.glyph_count  = 7'd127;
      end
      5: begin
        s.font_present = 1'b1;
        s.special_base = 6'd0;
        s.glyph_count  = 7'd64;
      end
      default: ;
    endcase
    return s;
  endfunction

  // Hold the request until it is taken; then maybe drop valid for a burst.
  task automatic send_request(input in_item_t req);
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_request(req);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_load(input logic [5:0] index, input logic [7:0] code);
    in_item_t req;
    req = random_request();
    req.cmd         = CMD_LOAD;
    req.glyph_index = index;
    req.glyph_code  = code;
    send_request(req);
  endtask

  // Well-formed strings frame first and last; broken ones flip them at random.
  // Table rewrites are slipped in between characters now and then.
  task automatic send_string(input int len, input bit broken, input bit digits_only);
    in_item_t req;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_load(6'($urandom_range(0, 63)),
                  $urandom_range(0, 1) ? pick_char() : 8'($urandom_range(0, 255)));
      req = char_request(digits_only ? CH_DIGIT_LO + 8'($urandom_range(0, 9)) : pick_char(),
                         i == 0, i == len - 1);
      if (broken) begin
        req.first = 1'($urandom);
        req.last  = 1'($urandom);
      end
      send_request(req);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    book.write_reg(idx, data);
  endtask

  // Write every register; junk goes in the unused upper bits and into one spare index.
  task automatic program_font(input cfg_t s);
    write_reg(REG_FONT_PRESENT, {6'($urandom), s.font_present});
    write_reg(REG_DIGIT_BASE,   {1'($urandom), s.digit_base});
    write_reg(REG_ALPHA_BASE,   {1'($urandom), s.alpha_base});
    write_reg(REG_SPECIAL_BASE, {1'($urandom), s.special_base});
    write_reg(REG_GLYPH_COUNT,  s.glyph_count);
    write_reg(REG_SPARE_LO + CFG_IDX_W'($urandom_range(0, 2)), CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Wait out every sprite still due, then give a search or a trailing load time to finish.
  task automatic drain();
    int waited;
    waited = 0;
    while (book.sprites_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    in_item_t req;
    cfg_t     s;
    int       mark;
    int       len;
    bit       broken;

    book = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers: no font, so nothing is drawn and the count stays zero,
    // but every character still takes a slot. No glyph entry is read here.
    for (int i = 0; i < 4; i++) send_request(char_request(PROBE_TEXT[i], i == 0, i == 3));

    // Fill the whole glyph table before any lookup can touch it. Plain entries hold codes from
    // 'A' to 'z' only, so the specials sit exactly at the search start, a little past it,
    // and at the last entry.
    for (int g = 0; g < GLYPHS_DEF; g++) begin
      if (g == int'(SPECIAL_BASE_RST))
        send_load(6'(g), CH_SPACE);
      else if (g == int'(SPECIAL_BASE_RST) + 4)
        send_load(6'(g), CH_PERIOD);
      else if (g == GLYPHS_DEF - 1)
        send_load(6'(g), CH_COLON);
      else
        send_load(6'(g), 8'($urandom_range(CH_UPPER_LO, CH_LOWER_HI)));
    end
    in_valid <= 1'b0;
    drain();

    s = '{font_present: 1'b1, digit_base: 6'd0, alpha_base: ALPHA_BASE_RST,
          special_base: SPECIAL_BASE_RST, glyph_count: 7'd64};
    program_font(s);

    // Start at the far corner so the slot and x both wrap within the string.
    for (int i = 0; i < 9; i++) begin
      req = char_request(CORNER_TEXT[i], i == 0, 1'b0);
      if (i == 0) begin
        req.start_x   = 9'h1FF;
        req.start_y   = 8'hFF;
        req.oam_start = 7'h7F;
        req.palette   = 4'hF;
      end
      send_request(req);
    end
    // Unknown codes carry on from the current string without a new first.
    for (int i = 0; i < 7; i++) send_request(char_request(STRAY_TEXT[i], 1'b0, i == 6));
    // One-character string at the origin.
    req = char_request(CH_COLON, 1'b1, 1'b1);
    req.start_x   = '0;
    req.start_y   = '0;
    req.oam_start = '0;
    req.palette   = '0;
    send_request(req);
    in_valid <= 1'b0;
    drain();

    // Shrink the font so mapped and searched indexes fall past its end.
    s.glyph_count = 7'd12;
    program_font(s);
    for (int i = 0; i < 3; i++) send_request(char_request(EDGE_TEXT[i], i == 0, i == 2));
    in_valid <= 1'b0;
    drain();

    // Random strings under a range of register settings; the last one runs flat out.
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      idle_on = (k != RANDOM_PHASES - 1);
      program_font(pick_setting(k));
      // Drive the drawn count into saturation with one long run of digits.
      if (k == 0) send_string(SATURATING_RUN, 1'b0, 1'b1);
      mark = book.loads_seen + book.chars_seen;
      while (book.loads_seen + book.chars_seen - mark < REQUESTS_PER_SET) begin
        broken = ($urandom_range(0, 6) == 0);
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        send_string(len, broken, 1'b0);
      end
      in_valid <= 1'b0;
      drain();
    end

    if (book.sprites_due.size() != 0) begin
      $error("%0d results never arrived", book.sprites_due.size());
      book.mismatches++;
    end
    $display("Covered %0d glyph loads and %0d characters (%0d drawn) over %0d register settings.",
             book.loads_seen, book.chars_seen, book.sprites_placed, settings_used);
    $display("Strings were framed and broken, with table rewrites, wraps and a saturated count.");
    if (book.mismatches == 0)
      $display("text_to_sprite_layout_top regression: pass");
    else
      $display("text_to_sprite_layout_top regression: fail");
    $finish;
  end

endmodule
